[rtl/tsed_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tab stop converter package
// Character codes, register map and default sizes shared by the converter.
// ----------------------------------------------------------------------------
package tsed_pkg;

  localparam int COLUMN_WIDTH_DEF = 16;
  localparam int MAX_STOP_DEF     = 63;
  localparam int STOP_WIDTH       = 6;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // A stored stop value of zero stands for these.
  localparam logic [STOP_WIDTH-1:0] FIRST_STOP_ZERO_AS   = 6'd1;
  localparam logic [STOP_WIDTH-1:0] STOP_SPACING_ZERO_AS = 6'd8;

  localparam logic [STOP_WIDTH-1:0] FIRST_STOP_RESET   = 6'd1;
  localparam logic [STOP_WIDTH-1:0] STOP_SPACING_RESET = 6'd8;

  // Register word index (byte address bits [3:2]).
  localparam logic [1:0] REG_MODE         = 2'd0;
  localparam logic [1:0] REG_FIRST_STOP   = 2'd1;
  localparam logic [1:0] REG_STOP_SPACING = 2'd2;

endpackage

[rtl/tsed_rem_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tab stop converter remainder unit
// Restoring remainder of a column offset by the stop spacing, one bit a cycle.
// ----------------------------------------------------------------------------
module tsed_rem_unit #(
  parameter int DW = tsed_pkg::COLUMN_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [DW-1:0]                  dividend,
  input  logic [tsed_pkg::STOP_WIDTH-1:0] divisor,
  output logic                           done,
  output logic [tsed_pkg::STOP_WIDTH-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] shreg;
  logic [tsed_pkg::STOP_WIDTH:0] trial;

  // Partial remainder stays below the divisor, so one more bit fits in seven.
  assign trial = {rem, shreg[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(DW);
        shreg <= dividend;
        rem   <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= tsed_pkg::STOP_WIDTH'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[tsed_pkg::STOP_WIDTH-1:0];
        end
        shreg <= shreg << 1;
        cnt   <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/tab_stop_entab_detab_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tab stop converter (entab / detab)
// Converts a text byte stream against programmable tab stops.
// ----------------------------------------------------------------------------
// Tab stops sit at column first_stop and every stop_spacing columns after it,
// counting columns from 0. With mode 0 the block holds back runs of spaces and
// sends one tab once a run reaches the next stop; any other byte, or an item
// with s_tlast set (end of text), first releases the held spaces. With mode 1
// each tab becomes spaces up to the next stop. A newline returns the column to
// 0, and the column saturates at its all-ones value. The last byte caused by
// an input item carries m_tlast. Timing: an input item is taken only while
// the block is idle, and the block then stays busy until its output bytes
// are produced, one byte a cycle into an output register while the output
// is not stalled. When a space (mode 0) or a tab (mode 1) lies at or past
// the first stop, the next stop is found by a bit-serial remainder unit;
// before the first stop the distance is a plain difference.
module tab_stop_entab_detab_unit #(
  parameter int COLUMN_WIDTH = tsed_pkg::COLUMN_WIDTH_DEF,
  parameter int MAX_STOP     = tsed_pkg::MAX_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,   // end_of_text
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] char_out
  output logic        m_tlast    // last_of_run
);

  localparam int SW = tsed_pkg::STOP_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  state_t st;

  // Configuration registers.
  logic          mode;
  logic [SW-1:0] first_stop;
  logic [SW-1:0] stop_spacing;

  // Converter state.
  logic [COLUMN_WIDTH-1:0] column;
  logic [SW-1:0]           pending;
  logic [SW-1:0]           spaces;
  logic                    send_ch;
  logic [7:0]              ch_r;

  logic                    accept;
  logic                    cfg_wr;
  logic [SW-1:0]           eff_first;
  logic [SW-1:0]           eff_spacing;
  logic                    near;
  logic                    needs_stop;
  logic                    resolve;
  logic                    div_start;
  logic                    div_done;
  logic [SW-1:0]           div_rem;
  logic [COLUMN_WIDTH-1:0] div_dividend;
  logic [SW-1:0]           stop_dist;
  logic [SW-1:0]           dist_clip;
  logic [COLUMN_WIDTH:0]   stop_sum;
  logic [COLUMN_WIDTH-1:0] stop_sat;
  logic [COLUMN_WIDTH:0]   adv_sum;
  logic [COLUMN_WIDTH-1:0] adv_sat;
  logic                    run_hits;
  logic [SW-1:0]           adv_extra;

  // --------------------------------------------------------------------------
  // Configuration port: writes complete in the access phase, never stalled.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      first_stop   <= tsed_pkg::FIRST_STOP_RESET;
      stop_spacing <= tsed_pkg::STOP_SPACING_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tsed_pkg::REG_MODE:         mode         <= pwdata[0];
        tsed_pkg::REG_FIRST_STOP:   first_stop   <= pwdata[SW-1:0];
        tsed_pkg::REG_STOP_SPACING: stop_spacing <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tsed_pkg::REG_MODE:         prdata = {31'd0, mode};
      tsed_pkg::REG_FIRST_STOP:   prdata = {{(32-SW){1'b0}}, first_stop};
      tsed_pkg::REG_STOP_SPACING: prdata = {{(32-SW){1'b0}}, stop_spacing};
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Next tab stop. Below the first stop the distance is a plain difference;
  // past it the distance is spacing minus (column - first) mod spacing, and
  // the remainder comes from the shared serial unit.
  // --------------------------------------------------------------------------
  assign eff_first   = (first_stop == '0) ? tsed_pkg::FIRST_STOP_ZERO_AS : first_stop;
  assign eff_spacing = (stop_spacing == '0) ? tsed_pkg::STOP_SPACING_ZERO_AS : stop_spacing;

  assign near         = column < COLUMN_WIDTH'(eff_first);
  assign div_dividend = column - COLUMN_WIDTH'(eff_first);

  assign stop_dist = (st == S_IDLE) ? (eff_first - column[SW-1:0]) : (eff_spacing - div_rem);

  // A tab never expands to more than MAX_STOP spaces.
  assign dist_clip = (stop_dist > SW'(MAX_STOP)) ? SW'(MAX_STOP) : stop_dist;

  assign stop_sum = {1'b0, column} + (COLUMN_WIDTH+1)'(stop_dist);
  assign stop_sat = stop_sum[COLUMN_WIDTH] ? '1 : stop_sum[COLUMN_WIDTH-1:0];

  // Held run plus this space reaches the stop.
  assign run_hits = ({1'b0, pending} + 7'd1) >= {1'b0, stop_dist};

  // Column after releasing held spaces (mode 0 only) and one passed byte.
  assign adv_extra = mode ? '0 : pending;
  assign adv_sum   = {1'b0, column} + (COLUMN_WIDTH+1)'(adv_extra) + (COLUMN_WIDTH+1)'(1);
  assign adv_sat   = adv_sum[COLUMN_WIDTH] ? '1 : adv_sum[COLUMN_WIDTH-1:0];

  assign s_tready   = (st == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign needs_stop = !s_tlast &&
                      (mode ? (s_tdata == tsed_pkg::CH_TAB) : (s_tdata == tsed_pkg::CH_SPACE));
  assign div_start  = accept && needs_stop && !near;
  assign resolve    = (accept && needs_stop && near) || ((st == S_DIV) && div_done);

  tsed_rem_unit #(
    .DW (COLUMN_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_spacing),
    .done     (div_done),
    .rem      (div_rem)
  );

  // --------------------------------------------------------------------------
  // Sequencer and output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      column   <= '0;
      pending  <= '0;
      spaces   <= '0;
      send_ch  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // The emit state reloads the output register on its own.
      if (m_tvalid && m_tready && st != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      if (resolve) begin
        if (mode) begin
          // Tab expands to spaces up to the stop.
          pending <= '0;
          spaces  <= dist_clip;
          send_ch <= 1'b0;
          column  <= stop_sat;
          st      <= S_EMIT;
        end else if (run_hits) begin
          // Held run collapses into a single tab.
          ch_r    <= tsed_pkg::CH_TAB;
          spaces  <= '0;
          send_ch <= 1'b1;
          column  <= stop_sat;
          pending <= '0;
          st      <= S_EMIT;
        end else begin
          pending <= pending + SW'(1);
          st      <= S_IDLE;
        end
      end else begin
        unique case (st)
          S_IDLE: begin
            if (div_start) begin
              st <= S_DIV;
            end else if (accept) begin
              // Release held spaces (mode 0), then pass the byte through unless it ends the text.
              ch_r    <= s_tdata;
              spaces  <= mode ? '0 : pending;
              send_ch <= !s_tlast;
              pending <= '0;
              if (s_tlast || s_tdata == tsed_pkg::CH_NEWLINE) begin
                column <= '0;
              end else begin
                column <= adv_sat;
              end
              if (s_tlast && (mode || pending == '0)) begin
                st <= S_IDLE;
              end else begin
                st <= S_EMIT;
              end
            end
          end
          S_DIV: begin
            st <= S_DIV;
          end
          S_EMIT: begin
            if (!m_tvalid || m_tready) begin
              m_tvalid <= 1'b1;
              if (spaces != '0) begin
                m_tdata <= tsed_pkg::CH_SPACE;
                m_tlast <= (spaces == SW'(1)) && !send_ch;
                spaces  <= spaces - SW'(1);
                if (spaces == SW'(1) && !send_ch) begin
                  st <= S_IDLE;
                end
              end else begin
                m_tdata <= ch_r;
                m_tlast <= 1'b1;
                send_ch <= 1'b0;
                st      <= S_IDLE;
              end
            end
          end
          default: st <= S_IDLE;
        endcase
      end
    end
  end

endmodule

[rtl/tsed_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tab stop converter checker
// Port-level checks on the output stream and input ready, bound to the converter top level.
// ----------------------------------------------------------------------------
module tsed_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // A stalled output item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  // Only spaces precede the final byte of a run.
  a_inner_space: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata == tsed_pkg::CH_SPACE)
    else $error("non-space byte inside an output run");

  // No new input is taken in the middle of an output run.
  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of an output run");

endmodule

bind tab_stop_entab_detab_unit tsed_checker u_tsed_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

[tb/sv/tsed_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tab stop converter stream checker
// Watches the configuration port and both streams, predicts the output bytes
// of every accepted input item and compares them in order with the output.
// ----------------------------------------------------------------------------
module tsed_stream_checker
  import tsed_pkg::*;
#(
  parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF,
  parameter int MAX_STOP     = MAX_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,   // end_of_text
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [7:0] char_out
  input  logic        m_tlast,   // last_of_run
  output int          errors,
  output int          backlog,
  output int          items_seen,
  output int          bytes_seen
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  localparam longint unsigned COL_TOP = (64'd1 << COLUMN_WIDTH) - 64'd1;

  out_byte_t expected_bytes[$];

  // Shadow of the converter's registers and its text position.
  logic                    conv_mode;
  logic [STOP_WIDTH-1:0]   stop_first;
  logic [STOP_WIDTH-1:0]   stop_gap;
  logic [COLUMN_WIDTH-1:0] col;
  logic [STOP_WIDTH-1:0]   held;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  // Smallest tab stop strictly to the right of column c.
  function automatic longint unsigned next_stop(input longint unsigned c);
    longint unsigned f;
    longint unsigned n;
    f = (stop_first == '0) ? longint'(FIRST_STOP_ZERO_AS) : longint'(stop_first);
    n = (stop_gap == '0) ? longint'(STOP_SPACING_ZERO_AS) : longint'(stop_gap);
    if (c < f) return f;
    return f + ((c - f) / n + 1) * n;
  endfunction

  function automatic logic [COLUMN_WIDTH-1:0] clamp_col(input longint unsigned v);
    if (v > COL_TOP) v = COL_TOP;
    return v[COLUMN_WIDTH-1:0];
  endfunction

  // Works out the bytes one input item causes and queues them.
  function automatic void convert_item(input logic [7:0] ch, input logic eot);
    out_byte_t       run[$];
    longint unsigned stop;
    longint unsigned gap_cols;
    if (conv_mode) begin
      // Spaces held over from entab mode vanish without moving the column.
      held = '0;
      if (eot) begin
        col = '0;
      end else if (ch == CH_TAB) begin
        stop     = next_stop(col);
        gap_cols = stop - col;
        if (gap_cols > MAX_STOP) gap_cols = MAX_STOP;
        repeat (gap_cols) run.push_back('{CH_SPACE, 1'b0});
        col = clamp_col(stop);
      end else begin
        run.push_back('{ch, 1'b0});
        col = (ch == CH_NEWLINE) ? '0 : clamp_col(longint'(col) + 1);
      end
    end else if (!eot && ch == CH_SPACE) begin
      stop     = next_stop(col);
      gap_cols = stop - col;
      if (longint'(held) + 1 >= gap_cols) begin
        run.push_back('{CH_TAB, 1'b0});
        col  = clamp_col(stop);
        held = '0;
      end else begin
        held = held + 1'b1;
      end
    end else begin
      repeat (held) run.push_back('{CH_SPACE, 1'b0});
      col  = clamp_col(longint'(col) + longint'(held));
      held = '0;
      if (eot) begin
        col = '0;
      end else begin
        run.push_back('{ch, 1'b0});
        col = (ch == CH_NEWLINE) ? '0 : clamp_col(longint'(col) + 1);
      end
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_bytes.push_back(run[i]);
  endfunction

  always @(posedge clk) begin
    out_byte_t want;
    if (rst) begin
      conv_mode  = 1'b0;
      stop_first = FIRST_STOP_RESET;
      stop_gap   = STOP_SPACING_RESET;
      col        = '0;
      held       = '0;
      errors     = 0;
      items_seen = 0;
      bytes_seen = 0;
      expected_bytes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h (last %0b) with nothing expected",
                                    m_tdata, m_tlast));
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want.ch)
            report_mismatch($sformatf("char_out %02h, expected %02h", m_tdata, want.ch));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last_of_run %0b, expected %0b on byte %02h",
                                      m_tlast, want.last, want.ch));
        end
      end
      if (s_tvalid && s_tready) begin
        items_seen++;
        convert_item(s_tdata, s_tlast);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MODE:         conv_mode  = pwdata[0];
          REG_FIRST_STOP:   stop_first = pwdata[STOP_WIDTH-1:0];
          REG_STOP_SPACING: stop_gap   = pwdata[STOP_WIDTH-1:0];
          default: ;
        endcase
      end
    end
    backlog = expected_bytes.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tab stop converter testbench
// Drives text items and register writes into the converter, with random idle
// cycles on both streams, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import tsed_pkg::*;

  // Quiet cycles after the last expected byte: covers a space or tab that
  // still runs through the bit-serial stop search without making output.
  localparam int DRAIN_CYCLES = COLUMN_WIDTH_DEF + 24;
  // Length of a receiver hold-off, long enough to back the block up.
  localparam int HOLD_CYCLES  = 400;
  localparam int SEG_ITEMS    = 42;
  // Detab tabs with stops every 63 columns; each one expands to a full run.
  localparam int LONG_TABS    = 4;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [7:0] char_in
  logic        s_tlast  = 1'b0; // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [7:0] char_out
  logic        m_tlast;         // last_of_run

  int errors;
  int backlog;
  int items_seen;
  int bytes_seen;

  // Idle rates in percent, and the hold-off requests for the receiver.
  int src_idle_pct  = 0;
  int snk_idle_pct  = 0;
  int hold_requests = 0;

  always #5 clk = ~clk;

  tab_stop_entab_detab_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  tsed_stream_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .errors     (errors),
    .backlog    (backlog),
    .items_seen (items_seen),
    .bytes_seen (bytes_seen)
  );

  // Receiver. It owns m_tready alone. A new hold-off request from the
  // stimulus starts a hold-off of the output, counted down here, so the
  // converter fills up and has to stall its input.
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Offers one item and returns at the edge that accepts it. It is always
  // entered just after a rising edge. The valid stays high on return so that
  // back-to-back items need no drop; drain_results lowers it.
  task automatic send_item(input logic [7:0] ch, input logic eot);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops the input and waits until every predicted byte has come out, plus
  // enough cycles for an item without output to finish its stop search.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, then the access cycle, then a quiet
  // cycle with psel low so that back-to-back writes never drive psel twice in one step.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Registers only change while the converter is idle.
  task automatic apply_stops(input logic mode, input logic [5:0] first,
                             input logic [5:0] gap);
    drain_results();
    write_reg(REG_MODE, {31'd0, mode});
    write_reg(REG_FIRST_STOP, {26'd0, first});
    write_reg(REG_STOP_SPACING, {26'd0, gap});
  endtask

  // Limit on the whole run.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int         seg;
    int         sent;
    int         pick;
    int         run_len;
    logic       seg_mode;
    logic [5:0] seg_first;
    logic [5:0] seg_gap;
    logic [7:0] ch;
    logic       eot;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 21;
    snk_idle_pct = 78;

    // ---- Directed part, reset settings: entab, stops at 1, 9, 17, ... ----
    // A space at column 0 already reaches the first stop and becomes a tab.
    send_item(CH_SPACE, 1'b0);
    send_item("A", 1'b0);
    // Three held spaces flushed ahead of an all-ones byte.
    repeat (3) send_item(CH_SPACE, 1'b0);
    send_item(8'hFF, 1'b0);
    // From column 6 the third space reaches column 9 and turns into a tab.
    repeat (3) send_item(CH_SPACE, 1'b0);
    // A tab passes through in entab mode and counts one column.
    send_item(CH_TAB, 1'b0);
    // End of text flushes the held spaces; its byte field is ignored.
    repeat (2) send_item(CH_SPACE, 1'b0);
    send_item(CH_SPACE, 1'b1);
    // End of text with nothing held makes no output at all.
    send_item(8'hAB, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(CH_NEWLINE, 1'b0);
    // Leave two spaces held, then switch to detab: they are dropped silently
    // and the column does not move for them.
    repeat (3) send_item(CH_SPACE, 1'b0);
    drain_results();
    write_reg(REG_MODE, 32'd1);
    send_item("q", 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_SPACE, 1'b1);
    // Zero stop registers stand for a first stop of 1 and a spacing of 8.
    apply_stops(1'b1, 6'd0, 6'd0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_TAB, 1'b0);
    send_item(CH_NEWLINE, 1'b0);
    // Stops moved under a held run: five spaces held against a stop at 8,
    // then the first stop drops to 3 and the next space emits one tab.
    apply_stops(1'b0, 6'd8, 6'd8);
    repeat (5) send_item(CH_SPACE, 1'b0);
    drain_results();
    write_reg(REG_FIRST_STOP, 32'd3);
    send_item(CH_SPACE, 1'b0);
    send_item(8'h7F, 1'b1);

    // ---- Longest runs, no idling to keep it short ----
    // Every tab gives the largest run of 63 spaces.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    apply_stops(1'b1, 6'd63, 6'd63);
    repeat (LONG_TABS) send_item(CH_TAB, 1'b0);
    send_item("m", 1'b0);
    // Back in entab mode, ten held spaces are released ahead of the next byte.
    drain_results();
    write_reg(REG_MODE, 32'd0);
    repeat (10) send_item(CH_SPACE, 1'b0);
    send_item("z", 1'b0);
    send_item(CH_SPACE, 1'b0);
    send_item(CH_SPACE, 1'b1);

    // ---- Random text in six settings ----
    // Mostly text lines with space runs and tabs, a few stream ends and raw
    // bytes. The idle pattern changes every two settings: slow receiver,
    // then slow sender, then no idling, where the receiver also holds off.
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0:       begin seg_mode = 1'b0; seg_first = 6'd1;  seg_gap = 6'd63; end
        1:       begin seg_mode = 1'b1; seg_first = 6'd63; seg_gap = 6'd1;  end
        2:       begin seg_mode = 1'b0; seg_first = 6'd0;  seg_gap = 6'd8;  end
        3:       begin seg_mode = 1'b1; seg_first = 6'd5;  seg_gap = 6'd0;  end
        4:       begin seg_mode = 1'b0; seg_first = 6'd63; seg_gap = 6'd4;  end
        default: begin seg_mode = 1'b1; seg_first = 6'd2;  seg_gap = 6'd63; end
      endcase
      apply_stops(seg_mode, seg_first, seg_gap);
      if (seg < 2) begin
        src_idle_pct = 21;
        snk_idle_pct = 78;
      end else if (seg < 4) begin
        src_idle_pct = 78;
        snk_idle_pct = 21;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      sent = 0;
      while (sent < SEG_ITEMS) begin
        if (seg >= 4 && sent == 0) hold_requests++;
        pick = $urandom_range(99);
        eot  = 1'b0;
        if (pick < 35) begin
          run_len = $urandom_range(10, 1);
          repeat (run_len) send_item(CH_SPACE, 1'b0);
          sent += run_len;
        end else begin
          if (pick < 45)      ch = CH_TAB;
          else if (pick < 52) ch = CH_NEWLINE;
          else if (pick < 56) begin
            ch  = 8'($urandom);
            eot = 1'b1;
          end else if (pick < 62) ch = 8'($urandom);
          else                    ch = 8'($urandom_range(126, 33));
          send_item(ch, eot);
          sent++;
        end
      end
    end

    drain_results();
    $display("Covered %0d input items and %0d output bytes in entab and detab modes,",
             items_seen, bytes_seen);
    $display("with zero and extreme stops, held-run flushes and full 63-space runs.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tsed_pkg.sv
rtl/tsed_rem_unit.sv
rtl/tab_stop_entab_detab_unit.sv
rtl/tsed_checker.sv
tb/sv/tsed_stream_checker.sv
tb/sv/tb_top.sv
